[src/bss_pkg.sv]
// ----------------------------------------------------------------------------
// Biphasic stimulus sequencer package
// Phase table, command codes and the types shared by the sequencer modules.
// ----------------------------------------------------------------------------
package bss_pkg;

  localparam int unsigned PhaseCount = 18;
  localparam int unsigned IdxW       = 5;
  localparam int unsigned TickW      = 16;
  localparam int unsigned MarkW      = 4;

  localparam logic [TickW-1:0] PhaseTicksRst = 16'd200;
  localparam logic [TickW-1:0] GapTicksRst   = 16'd500;

  // command characters
  localparam logic [7:0] CmdS   = 8'h73;
  localparam logic [7:0] CmdK   = 8'h4B;
  localparam logic [7:0] CmdZ   = 8'h5A;
  localparam logic [7:0] CmdN   = 8'h4E;
  localparam logic [7:0] CmdAll = 8'h2B;

  localparam logic ModeCmd  = 1'b0;
  localparam logic ModeTick = 1'b1;

  typedef enum logic [2:0] {
    SelS   = 3'd0,
    SelK   = 3'd1,
    SelZ   = 3'd2,
    SelN   = 3'd3,
    SelAll = 3'd4
  } sel_e;

  typedef struct packed {
    logic             a;
    logic             b;
    logic             gap;
    logic [MarkW-1:0] mark;
  } phase_t;

  localparam phase_t PhaseTab [PhaseCount] = '{
    '{1'b1, 1'b0, 1'b0, 4'h1}, '{1'b0, 1'b1, 1'b0, 4'h0}, '{1'b0, 1'b0, 1'b0, 4'h0},
    '{1'b0, 1'b0, 1'b1, 4'h0},
    '{1'b1, 1'b0, 1'b0, 4'h2}, '{1'b0, 1'b0, 1'b0, 4'h0}, '{1'b0, 1'b1, 1'b0, 4'h0},
    '{1'b0, 1'b0, 1'b0, 4'h0},
    '{1'b0, 1'b0, 1'b1, 4'h0},
    '{1'b0, 1'b1, 1'b0, 4'h4}, '{1'b1, 1'b0, 1'b0, 4'h0}, '{1'b0, 1'b0, 1'b0, 4'h0},
    '{1'b0, 1'b0, 1'b1, 4'h0},
    '{1'b0, 1'b1, 1'b0, 4'h8}, '{1'b0, 1'b0, 1'b0, 4'h0}, '{1'b1, 1'b0, 1'b0, 4'h0},
    '{1'b0, 1'b0, 1'b0, 4'h0},
    '{1'b0, 1'b0, 1'b1, 4'h0}
  };

  // request to enter a phase, skipping zero-length ones
  typedef struct packed {
    logic [IdxW-1:0] first;
    logic [IdxW-1:0] stop;
    logic            phase_nz;
    logic            gap_nz;
  } entry_req_t;

  typedef struct packed {
    logic             landed;
    logic [IdxW-1:0]  idx;
    logic [MarkW-1:0] toggle;
  } entry_res_t;

  function automatic logic [IdxW-1:0] pat_first(sel_e sel);
    logic [IdxW-1:0] r;
    unique case (sel)
      SelS:    r = 5'd0;
      SelK:    r = 5'd4;
      SelZ:    r = 5'd9;
      SelN:    r = 5'd13;
      SelAll:  r = 5'd0;
      default: r = 5'd0;
    endcase
    return r;
  endfunction

  function automatic logic [IdxW-1:0] pat_end(sel_e sel);
    logic [IdxW-1:0] r;
    unique case (sel)
      SelS:    r = 5'd3;
      SelK:    r = 5'd8;
      SelZ:    r = 5'd12;
      SelN:    r = 5'd17;
      SelAll:  r = 5'd18;
      default: r = 5'd18;
    endcase
    return r;
  endfunction

endpackage

[src/bss_phase_entry.sv]
// ----------------------------------------------------------------------------
// Phase entry
// Finds the first phase of non-zero length from a start index up to the
// sequence end and collects the marker toggles of the phases passed.
// ----------------------------------------------------------------------------
module bss_phase_entry (
  input  bss_pkg::entry_req_t req_i,
  output bss_pkg::entry_res_t res_o
);

  always_comb begin
    logic nz;
    res_o = '0;
    for (int j = 0; j < bss_pkg::PhaseCount; j++) begin
      nz = bss_pkg::PhaseTab[j].gap ? req_i.gap_nz : req_i.phase_nz;
      if (!res_o.landed && (bss_pkg::IdxW'(j) >= req_i.first) &&
          (bss_pkg::IdxW'(j) < req_i.stop)) begin
        res_o.toggle = res_o.toggle ^ bss_pkg::PhaseTab[j].mark;
        if (nz) begin
          res_o.landed = 1'b1;
          res_o.idx    = bss_pkg::IdxW'(j);
        end
      end
    end
  end

endmodule

[src/biphasic_stimulus_sequencer_unit.sv]
// ----------------------------------------------------------------------------
// Biphasic stimulus sequencer
// The result of an accepted request is registered in the output register.
// Throughput: one request per cycle while the output is not stalled, set by
// the single state update pass; the output register frees as its result is taken.
// Reset: sequencer idle, markers clear, phase_ticks 200, gap_ticks 500.
// ----------------------------------------------------------------------------
module biphasic_stimulus_sequencer_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // command / tick channel
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        mode_i,
  input  logic [7:0]                  command_byte_i,
  // result channel
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic                        drive_a_o,
  output logic                        drive_b_o,
  output logic [bss_pkg::MarkW-1:0]   pattern_markers_o,
  output logic                        busy_res_o,
  // configuration
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [2:0]                  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  logic [bss_pkg::TickW-1:0] phase_ticks_q, gap_ticks_q;
  logic                      running_q, running_d;
  bss_pkg::sel_e             sel_q, sel_d;
  logic [bss_pkg::IdxW-1:0]  phase_q, phase_d;
  logic [bss_pkg::TickW-1:0] tick_q, tick_d;
  logic [bss_pkg::MarkW-1:0] marker_q, marker_d;

  logic                      out_valid_q;
  logic                      drive_a_q, drive_a_d, drive_b_q, drive_b_d;
  logic [bss_pkg::MarkW-1:0] markers_q;
  logic                      busy_q;

  logic                      in_accept, cfg_wr;
  bss_pkg::entry_req_t       ereq;
  bss_pkg::entry_res_t       eres;
  logic                      do_enter;

  assign pready     = 1'b1;
  assign cfg_wr     = psel & penable & pwrite;
  assign prdata     = {16'h0, paddr[2] ? gap_ticks_q : phase_ticks_q};
  assign in_stall_o = out_valid_q & out_stall_i;
  assign in_accept  = in_valid_i & ~in_stall_o;

  bss_phase_entry u_entry (
    .req_i (ereq),
    .res_o (eres)
  );

  always_comb begin
    bss_pkg::phase_t           cur;
    logic [bss_pkg::TickW-1:0] cur_len;
    logic [bss_pkg::TickW:0]   next_cnt;
    logic                      cmd_ok;
    bss_pkg::sel_e             cmd_sel;

    running_d = running_q;
    sel_d     = sel_q;
    phase_d   = phase_q;
    tick_d    = tick_q;
    marker_d  = marker_q;
    drive_a_d = 1'b0;
    drive_b_d = 1'b0;
    do_enter  = 1'b0;

    cur      = (phase_q < bss_pkg::IdxW'(bss_pkg::PhaseCount)) ?
               bss_pkg::PhaseTab[phase_q] : '0;
    cur_len  = cur.gap ? gap_ticks_q : phase_ticks_q;
    next_cnt = {1'b0, tick_q} + {{bss_pkg::TickW{1'b0}}, 1'b1};

    cmd_ok  = 1'b1;
    cmd_sel = bss_pkg::SelS;
    unique case (command_byte_i)
      bss_pkg::CmdS:   cmd_sel = bss_pkg::SelS;
      bss_pkg::CmdK:   cmd_sel = bss_pkg::SelK;
      bss_pkg::CmdZ:   cmd_sel = bss_pkg::SelZ;
      bss_pkg::CmdN:   cmd_sel = bss_pkg::SelN;
      bss_pkg::CmdAll: cmd_sel = bss_pkg::SelAll;
      default:         cmd_ok  = 1'b0;
    endcase

    ereq.phase_nz = |phase_ticks_q;
    ereq.gap_nz   = |gap_ticks_q;
    ereq.first    = phase_q + bss_pkg::IdxW'(1);
    ereq.stop     = bss_pkg::pat_end(sel_q);

    if (mode_i == bss_pkg::ModeCmd) begin
      if (!running_q && cmd_ok) begin
        sel_d      = cmd_sel;
        ereq.first = bss_pkg::pat_first(cmd_sel);
        ereq.stop  = bss_pkg::pat_end(cmd_sel);
        do_enter   = 1'b1;
      end
    end else if (running_q) begin
      if (phase_q >= bss_pkg::IdxW'(bss_pkg::PhaseCount)) begin
        running_d = 1'b0;
        phase_d   = '0;
        tick_d    = '0;
      end else begin
        drive_a_d = cur.a;
        drive_b_d = cur.b;
        if (next_cnt >= {1'b0, cur_len}) begin
          do_enter = 1'b1;
        end else begin
          tick_d = next_cnt[bss_pkg::TickW-1:0];
        end
      end
    end

    if (do_enter) begin
      marker_d  = marker_q ^ eres.toggle;
      running_d = eres.landed;
      phase_d   = eres.landed ? eres.idx : '0;
      tick_d    = '0;
    end

    if ((mode_i == bss_pkg::ModeCmd) && running_d &&
        (phase_d < bss_pkg::IdxW'(bss_pkg::PhaseCount))) begin
      drive_a_d = bss_pkg::PhaseTab[phase_d].a;
      drive_b_d = bss_pkg::PhaseTab[phase_d].b;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_ticks_q <= bss_pkg::PhaseTicksRst;
      gap_ticks_q   <= bss_pkg::GapTicksRst;
      running_q     <= 1'b0;
      sel_q         <= bss_pkg::SelS;
      phase_q       <= '0;
      tick_q        <= '0;
      marker_q      <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      if (cfg_wr) begin
        if (paddr[2]) begin
          gap_ticks_q <= pwdata[bss_pkg::TickW-1:0];
        end else begin
          phase_ticks_q <= pwdata[bss_pkg::TickW-1:0];
        end
      end
      if (in_accept) begin
        running_q <= running_d;
        sel_q     <= sel_d;
        phase_q   <= phase_d;
        tick_q    <= tick_d;
        marker_q  <= marker_d;
      end
      out_valid_q <= in_accept | (out_valid_q & out_stall_i);
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      drive_a_q <= drive_a_d;
      drive_b_q <= drive_b_d;
      markers_q <= marker_d;
      busy_q    <= running_d;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign drive_a_o         = drive_a_q;
  assign drive_b_o         = drive_b_q;
  assign pattern_markers_o = markers_q;
  assign busy_res_o        = busy_q;

endmodule
